@@ hdl/mamc_pkg.sv @@
//------------------------------------------------------------------------------
// mamc_pkg
// Shared types and defaults of the moving average / median cascade.
//------------------------------------------------------------------------------
`default_nettype none

package mamc_pkg;

	localparam int unsigned SAMPLE_W     = 16;
	localparam int unsigned AVG_TAPS_DEF = 8;
	localparam int unsigned MED_TAPS_DEF = 5;

	typedef logic signed [SAMPLE_W-1:0] sample_t;

	// request kind
	typedef enum logic {
		MODE_FILTER  = 1'b0,
		MODE_PREFILL = 1'b1
	} mode_t;

	// control that travels with a request from the average front end
	typedef struct packed {
		logic prefill;
		logic full;
	} avg_ctl_t;

endpackage

`default_nettype wire

@@ hdl/mamc_in_if.sv @@
//------------------------------------------------------------------------------
// mamc_in_if
// Input request channel: valid/ready handshake with mode and sample.
//------------------------------------------------------------------------------
`default_nettype none

interface mamc_in_if;

	logic              valid;
	logic              ready;
	logic              mode;
	mamc_pkg::sample_t sample;

	modport source (output valid, output mode, output sample, input ready);
	modport sink   (input valid, input mode, input sample, output ready);

endinterface

`default_nettype wire

@@ hdl/mamc_out_if.sv @@
//------------------------------------------------------------------------------
// mamc_out_if
// Result channel: valid/ready handshake with the filtered sample.
//------------------------------------------------------------------------------
`default_nettype none

interface mamc_out_if;

	logic              valid;
	logic              ready;
	mamc_pkg::sample_t filtered;

	modport source (output valid, output filtered, input ready);
	modport sink   (input valid, input filtered, output ready);

endinterface

`default_nettype wire

@@ hdl/mamc_avg.sv @@
//------------------------------------------------------------------------------
// mamc_avg
// Moving average front end: sample delay line, running total, fill tracking.
//------------------------------------------------------------------------------
`default_nettype none

module mamc_avg #(
	parameter int unsigned AVG_TAPS = mamc_pkg::AVG_TAPS_DEF,
	localparam int unsigned TOT_W = mamc_pkg::SAMPLE_W + $clog2(AVG_TAPS)
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic                    in_mode,
	input  mamc_pkg::sample_t       in_sample,
	output logic                    out_valid,
	input  logic                    out_ready,
	output mamc_pkg::avg_ctl_t      out_ctl,
	output mamc_pkg::sample_t       out_raw,
	output logic signed [TOT_W-1:0] out_total
);

	localparam int unsigned SW    = mamc_pkg::SAMPLE_W;
	localparam int unsigned POS_W = $clog2(AVG_TAPS);
	localparam int unsigned EXT_W = TOT_W - SW;
	localparam logic [POS_W-1:0] POS_LAST = POS_W'(AVG_TAPS - 1);
	localparam logic signed [TOT_W-1:0] TOT_SCALE = TOT_W'(AVG_TAPS);

	mamc_pkg::sample_t       ring_q [AVG_TAPS];
	logic [POS_W-1:0]        pos_q;
	logic                    full_q;
	logic signed [TOT_W-1:0] tot_q;

	logic signed [TOT_W-1:0] x_ext;
	logic signed [TOT_W-1:0] old_ext;
	logic signed [TOT_W-1:0] tot_nxt;
	logic signed [TOT_W-1:0] tot_pre;
	logic                    full_nxt;
	logic                    accept;
	logic                    prefill;

	logic                    v_s1;
	mamc_pkg::avg_ctl_t      ctl_s1;
	mamc_pkg::sample_t       raw_s1;
	logic signed [TOT_W-1:0] tot_s1;

	assign in_ready = !v_s1 || out_ready;
	assign accept   = in_valid && in_ready;
	assign prefill  = (in_mode == mamc_pkg::MODE_PREFILL);

	// oldest entry leaves the total only once the line has been filled
	always_comb begin
		x_ext    = {{EXT_W{in_sample[SW-1]}}, in_sample};
		old_ext  = full_q ? {{EXT_W{ring_q[AVG_TAPS-1][SW-1]}}, ring_q[AVG_TAPS-1]} : '0;
		tot_nxt  = tot_q - old_ext + x_ext;
		tot_pre  = TOT_W'(x_ext * TOT_SCALE);
		full_nxt = full_q || (pos_q == POS_LAST);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			full_q <= 1'b0;
			tot_q  <= '0;
			v_s1   <= 1'b0;
		end else begin
			if (in_ready) begin
				v_s1 <= in_valid;
			end
			if (accept) begin
				if (prefill) begin
					full_q <= 1'b1;
					tot_q  <= tot_pre;
				end else begin
					full_q <= full_nxt;
					tot_q  <= tot_nxt;
					if (!full_q) begin
						pos_q <= pos_q + 1'b1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			if (prefill) begin
				for (int i = 0; i < AVG_TAPS; i++) begin
					ring_q[i] <= in_sample;
				end
			end else begin
				ring_q[0] <= in_sample;
				for (int i = 1; i < AVG_TAPS; i++) begin
					ring_q[i] <= ring_q[i-1];
				end
			end
		end
		if (in_ready) begin
			ctl_s1.prefill <= prefill;
			ctl_s1.full    <= prefill || full_nxt;
			raw_s1         <= in_sample;
			tot_s1         <= prefill ? tot_pre : tot_nxt;
		end
	end

	assign out_valid = v_s1;
	assign out_ctl   = ctl_s1;
	assign out_raw   = raw_s1;
	assign out_total = tot_s1;

	// once filled, the line stays filled
	assert property (@(posedge clk) disable iff (!arst_n) full_q |=> full_q)
		else $error("average fill flag dropped");

endmodule

`default_nettype wire

@@ hdl/mamc_div.sv @@
//------------------------------------------------------------------------------
// mamc_div
// Divide of the running total by the tap count, truncated toward zero.
//------------------------------------------------------------------------------
`default_nettype none

module mamc_div #(
	parameter int unsigned AVG_TAPS = mamc_pkg::AVG_TAPS_DEF,
	localparam int unsigned TOT_W = mamc_pkg::SAMPLE_W + $clog2(AVG_TAPS)
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  mamc_pkg::avg_ctl_t      in_ctl,
	input  mamc_pkg::sample_t       in_raw,
	input  logic signed [TOT_W-1:0] in_total,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic                    out_prefill,
	output mamc_pkg::sample_t       out_avg
);

	localparam int unsigned SW      = mamc_pkg::SAMPLE_W;
	localparam int unsigned SHIFT   = TOT_W + $clog2(AVG_TAPS);
	localparam int unsigned RECIP_W = TOT_W + 2;
	localparam int unsigned PROD_W  = TOT_W + RECIP_W;
	// reciprocal rounded up; exact floor for any magnitude below 2**TOT_W
	localparam longint unsigned RECIP_VAL = (64'd1 << SHIFT) / AVG_TAPS + 64'd1;
	localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_VAL);

	logic [TOT_W-1:0]  mag;
	logic [PROD_W-1:0] prod;
	logic              rdy3;

	logic               v_s2;
	mamc_pkg::avg_ctl_t ctl_s2;
	mamc_pkg::sample_t  raw_s2;
	logic [SW-1:0]      q_s2;
	logic               neg_s2;

	logic               v_s3;
	logic               pre_s3;
	mamc_pkg::sample_t  avg_s3;

	assign rdy3     = !v_s3 || out_ready;
	assign in_ready = !v_s2 || rdy3;

	always_comb begin
		mag  = in_total[TOT_W-1] ? TOT_W'(-in_total) : TOT_W'(in_total);
		prod = PROD_W'(mag) * PROD_W'(RECIP);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (in_ready) begin
				v_s2 <= in_valid;
			end
			if (rdy3) begin
				v_s3 <= v_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready) begin
			ctl_s2 <= in_ctl;
			raw_s2 <= in_raw;
			q_s2   <= prod[SHIFT +: SW];
			neg_s2 <= in_total[TOT_W-1];
		end
		if (rdy3) begin
			pre_s3 <= ctl_s2.prefill;
			// raw sample passes until the line has been filled
			if (ctl_s2.full) begin
				avg_s3 <= neg_s2 ? -$signed(q_s2) : $signed(q_s2);
			end else begin
				avg_s3 <= raw_s2;
			end
		end
	end

	assign out_valid   = v_s3;
	assign out_prefill = pre_s3;
	assign out_avg     = avg_s3;

	// a stalled quotient holds until it moves on
	assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 && !rdy3 |=> v_s2 && $stable(q_s2))
		else $error("stalled quotient lost");

endmodule

`default_nettype wire

@@ hdl/mamc_med.sv @@
//------------------------------------------------------------------------------
// mamc_med
// Median window: shift in averaged value, rank select, result register.
//------------------------------------------------------------------------------
`default_nettype none

module mamc_med #(
	parameter int unsigned MED_TAPS = mamc_pkg::MED_TAPS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              in_prefill,
	input  mamc_pkg::sample_t in_avg,
	output logic              out_valid,
	input  logic              out_ready,
	output mamc_pkg::sample_t out_filtered
);

	localparam int unsigned FILL_W = $clog2(MED_TAPS + 1);
	localparam int unsigned RANK_W = $clog2(MED_TAPS);
	localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(MED_TAPS);
	localparam logic [RANK_W-1:0] MID       = RANK_W'(MED_TAPS / 2);

	mamc_pkg::sample_t win_q   [MED_TAPS];
	mamc_pkg::sample_t win_nxt [MED_TAPS];
	logic [FILL_W-1:0] fill_q;
	logic [FILL_W-1:0] fill_nxt;
	logic [MED_TAPS-1:0] below [MED_TAPS];
	logic [RANK_W-1:0]   rank  [MED_TAPS];
	mamc_pkg::sample_t median;
	mamc_pkg::sample_t result;
	logic              fire;
	logic              out_valid_q;
	mamc_pkg::sample_t filtered_q;

	assign in_ready = !out_valid_q || out_ready;
	assign fire     = in_valid && in_ready;

	always_comb begin
		for (int i = 0; i < MED_TAPS - 1; i++) begin
			win_nxt[i] = win_q[i+1];
		end
		win_nxt[MED_TAPS-1] = in_avg;
		fill_nxt = (fill_q == FILL_FULL) ? fill_q : fill_q + 1'b1;
	end

	// rank of each entry, ties broken by age; exactly one entry sits at the middle
	always_comb begin
		for (int i = 0; i < MED_TAPS; i++) begin
			for (int j = 0; j < MED_TAPS; j++) begin
				below[i][j] = (win_nxt[j] < win_nxt[i]) ||
					((j < i) && (win_nxt[j] == win_nxt[i]));
			end
			rank[i] = RANK_W'($countones(below[i]));
		end
		median = '0;
		for (int i = 0; i < MED_TAPS; i++) begin
			if (rank[i] == MID) begin
				median = median | win_nxt[i];
			end
		end
		result = (fill_nxt == FILL_FULL) ? median : in_avg;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (fire) begin
				out_valid_q <= !in_prefill;
				fill_q      <= in_prefill ? FILL_FULL : fill_nxt;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			if (in_prefill) begin
				for (int i = 0; i < MED_TAPS; i++) begin
					win_q[i] <= in_avg;
				end
			end else begin
				win_q <= win_nxt;
			end
			filtered_q <= result;
		end
	end

	assign out_valid    = out_valid_q;
	assign out_filtered = filtered_q;

	assert property (@(posedge clk) disable iff (!arst_n) fill_q <= FILL_FULL)
		else $error("median fill count out of range");

	// a prefill request never leaves a result behind
	assert property (@(posedge clk) disable iff (!arst_n)
		fire && in_prefill |=> !out_valid_q)
		else $error("prefill produced a result");

endmodule

`default_nettype wire

@@ hdl/moving_average_median_cascade_unit.sv @@
//------------------------------------------------------------------------------
// moving_average_median_cascade_unit
// Signed sample cleaner: moving average followed by a sliding median.
//------------------------------------------------------------------------------
// usage
//   din  : request channel (valid/ready) with mode and a signed 16-bit sample.
//          mode filter -> one result on dout; mode prefill -> loads every tap of
//          both windows with the sample, marks them full, gives no result.
//   dout : result channel (valid/ready) with the filtered sample.
//   path      : a taken request is registered in turn by the running total,
//               reciprocal multiply, sign/select and median rank stages.
//   throughput: one request per cycle unless stalled; every stage has its own
//               valid bit; bubbles close up, requests flow while a result waits.
//   stall     : a result held on dout backs up stage by stage; din.ready drops
//               only when all four stages hold work.
//   reset     : arst_n clears the running total, fill flags and valid bits;
//               the sample line and median window need no clearing since their
//               entries are read only after being written.
//   until the average line has seen AVG_TAPS samples the raw sample passes
//   through it; until the median has seen MED_TAPS values the averaged value
//   passes through it.
//------------------------------------------------------------------------------
`default_nettype none

module moving_average_median_cascade_unit #(
	parameter int unsigned AVG_TAPS = mamc_pkg::AVG_TAPS_DEF,
	parameter int unsigned MED_TAPS = mamc_pkg::MED_TAPS_DEF
) (
	input logic         clk,
	input logic         arst_n,
	mamc_in_if.sink     din,
	mamc_out_if.source  dout
);

	localparam int unsigned TOT_W = mamc_pkg::SAMPLE_W + $clog2(AVG_TAPS);

	// average front end -> divider
	logic                    avg_valid;
	logic                    avg_ready;
	mamc_pkg::avg_ctl_t      avg_ctl;
	mamc_pkg::sample_t       avg_raw;
	logic signed [TOT_W-1:0] avg_total;

	// divider -> median
	logic                    div_valid;
	logic                    div_ready;
	logic                    div_prefill;
	mamc_pkg::sample_t       div_avg;

	// running total over the sample line, fill tracking, prefill load
	mamc_avg #(
		.AVG_TAPS (AVG_TAPS)
	) u_avg (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (din.valid),
		.in_ready  (din.ready),
		.in_mode   (din.mode),
		.in_sample (din.sample),
		.out_valid (avg_valid),
		.out_ready (avg_ready),
		.out_ctl   (avg_ctl),
		.out_raw   (avg_raw),
		.out_total (avg_total)
	);

	// total / AVG_TAPS by reciprocal multiply, then sign restore and pass-through
	mamc_div #(
		.AVG_TAPS (AVG_TAPS)
	) u_div (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (avg_valid),
		.in_ready    (avg_ready),
		.in_ctl      (avg_ctl),
		.in_raw      (avg_raw),
		.in_total    (avg_total),
		.out_valid   (div_valid),
		.out_ready   (div_ready),
		.out_prefill (div_prefill),
		.out_avg     (div_avg)
	);

	// median window and output register
	mamc_med #(
		.MED_TAPS (MED_TAPS)
	) u_med (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (div_valid),
		.in_ready     (div_ready),
		.in_prefill   (div_prefill),
		.in_avg       (div_avg),
		.out_valid    (dout.valid),
		.out_ready    (dout.ready),
		.out_filtered (dout.filtered)
	);

	// input backs up only behind a result that the receiver is holding off
	assert property (@(posedge clk) disable iff (!arst_n)
		!din.ready |-> dout.valid && !dout.ready)
		else $error("input stalled with no result waiting");

endmodule

`default_nettype wire
